// File: rtl/mfk_pkg.sv
// ----------------------------------------------------------------------------
// mfk_pkg: shared types and constants of the multi-face link keepalive
// Item and result layouts, event and mode codes, register indexes, reset
// values and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mfk_pkg;

  // Default number of faces
  localparam int FACES_DEF = 6;

  // Faces covered by the busy mask; faces above it are never busy
  localparam int BUSY_W = 6;

  // Register reset values
  localparam logic [15:0] RX_EXPIRE_RST = 16'd200;
  localparam logic [15:0] TX_PROBE_RST  = 16'd150;
  localparam logic [15:0] LOCKOUT_RST   = 16'd2000;
  localparam logic [7:0]  USER_TYPE_RST = 8'd0;
  localparam logic [7:0]  SLEEP_VAL_RST = 8'd0;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_RX_EXPIRE = 3'd0;
  localparam logic [2:0] REG_TX_PROBE  = 3'd1;
  localparam logic [2:0] REG_LOCKOUT   = 3'd2;
  localparam logic [2:0] REG_USER_TYPE = 3'd3;
  localparam logic [2:0] REG_SLEEP_VAL = 3'd4;

  // Transmit header bytes
  localparam logic [7:0] HDR_NORMAL   = 8'h80;
  localparam logic [7:0] HDR_POSTPONE = 8'hC0;
  localparam logic [1:0] LEN_SHORT    = 2'd1;
  localparam logic [1:0] LEN_LONG     = 2'd2;

  typedef enum logic [1:0] {
    MODE_RX    = 2'd0,
    MODE_SEND  = 2'd1,
    MODE_SET   = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_TX          = 3'd0,
    EV_POSTPONE    = 3'd1,
    EV_WARM_SLEEP  = 3'd2,
    EV_RESET_TIMER = 3'd3,
    EV_STATUS      = 3'd4
  } ev_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EVT,
    ST_SEND,
    ST_STAT
  } state_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  face;
    logic [31:0] now_ms;
    logic [31:0] real_ms;
    logic [7:0]  packet_type;
    logic [7:0]  packet_len;
    logic [7:0]  value_byte;
    logic [7:0]  header_byte;
    logic [5:0]  busy_mask;
    logic        all_faces;
  } item_t;

  typedef struct packed {
    ev_t        event_res;
    logic [2:0] event_face;
    logic [7:0] tx_value;
    logic [7:0] tx_header;
    logic [1:0] tx_len;
    logic [7:0] last_value;
    logic       expired;
    logic       alone;
    logic       changed;
    logic       last;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic cnt_clr;
    logic cnt_inc;
    logic emit_evt;
    logic emit_tx;
    logic send_upd;
    logic emit_stat;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  ev_any;
    logic  slot_free;
    logic  due;
    logic  busy;
    logic  cnt_last;
  } sts_t;

endpackage

// File: rtl/mfk_in_if.sv
// ----------------------------------------------------------------------------
// mfk_in_if: request channel of the link keepalive
// Valid/ready handshake carrying one link request.
// ----------------------------------------------------------------------------
interface mfk_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  face;
  logic [31:0] now_ms;
  logic [31:0] real_ms;
  logic [7:0]  packet_type;
  logic [7:0]  packet_len;
  logic [7:0]  value_byte;
  logic [7:0]  header_byte;
  logic [5:0]  busy_mask;
  logic        all_faces;

  modport source (
    output valid, mode, face, now_ms, real_ms, packet_type, packet_len,
           value_byte, header_byte, busy_mask, all_faces,
    input  ready
  );

  modport sink (
    input  valid, mode, face, now_ms, real_ms, packet_type, packet_len,
           value_byte, header_byte, busy_mask, all_faces,
    output ready
  );
endinterface

// File: rtl/mfk_out_if.sv
// ----------------------------------------------------------------------------
// mfk_out_if: result channel of the link keepalive
// Valid/ready handshake carrying one event or status result.
// ----------------------------------------------------------------------------
interface mfk_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [2:0] event_face;
  logic [7:0] tx_value;
  logic [7:0] tx_header;
  logic [1:0] tx_len;
  logic [7:0] last_value;
  logic       expired;
  logic       alone;
  logic       changed;
  logic       last;

  modport source (
    output valid, event_res, event_face, tx_value, tx_header, tx_len,
           last_value, expired, alone, changed, last,
    input  ready
  );

  modport sink (
    input  valid, event_res, event_face, tx_value, tx_header, tx_len,
           last_value, expired, alone, changed, last,
    output ready
  );
endinterface

// File: rtl/mfk_cfg_if.sv
// ----------------------------------------------------------------------------
// mfk_cfg_if: configuration write channel of the link keepalive
// Valid/ready handshake carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mfk_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/multi_face_link_keepalive.sv
// Sequence: a request is accepted, applied, then closed by its status result;
// a receive request emits its events first, one per free result slot.
// A send pass walks the faces one per cycle; a due, idle face waits there
// for a free result slot. Only one request at a time; the next is taken
// when the controller is back in idle.
// Reset: rst_n (synchronous) restores register defaults and clears face state.
// ----------------------------------------------------------------------------
// multi_face_link_keepalive: per-face link keepalive manager
// Tracks neighbor expiry, probe times and the viral postpone request for
// each face, emitting transmit frames, link events and a status per request.
// ----------------------------------------------------------------------------
module multi_face_link_keepalive #(
  parameter int FACES = mfk_pkg::FACES_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  mfk_in_if.sink    in_ch,
  mfk_out_if.source out_ch,
  mfk_cfg_if.sink   cfg_ch
);
  import mfk_pkg::*;

  item_t item;
  cmd_t  cmd;
  sts_t  sts;
  res_t  res;
  logic  out_valid;

  // Pack the request
  always_comb begin
    item.mode        = mode_t'(in_ch.mode);
    item.face        = in_ch.face;
    item.now_ms      = in_ch.now_ms;
    item.real_ms     = in_ch.real_ms;
    item.packet_type = in_ch.packet_type;
    item.packet_len  = in_ch.packet_len;
    item.value_byte  = in_ch.value_byte;
    item.header_byte = in_ch.header_byte;
    item.busy_mask   = in_ch.busy_mask;
    item.all_faces   = in_ch.all_faces;
  end

  assign cfg_ch.ready = 1'b1;

  mfk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfk_dp #(.FACES(FACES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_in   (item),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .res       (res)
  );

  // Drive the result channel
  assign out_ch.valid      = out_valid;
  assign out_ch.event_res  = res.event_res;
  assign out_ch.event_face = res.event_face;
  assign out_ch.tx_value   = res.tx_value;
  assign out_ch.tx_header  = res.tx_header;
  assign out_ch.tx_len     = res.tx_len;
  assign out_ch.last_value = res.last_value;
  assign out_ch.expired    = res.expired;
  assign out_ch.alone      = res.alone;
  assign out_ch.changed    = res.changed;
  assign out_ch.last       = res.last;

  // One request in flight: no second acceptance right after the first
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  // The final result is always a status
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |-> (out_ch.event_res == EV_STATUS))
    else $error("final result is not a status");

  // A long frame always carries the postpone header
  a_tx_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.event_res == EV_TX) |->
      ((out_ch.tx_len == LEN_LONG) == (out_ch.tx_header == HDR_POSTPONE)))
    else $error("transmit length and header disagree");

  // Only transmit frames carry a length other than one
  a_tx_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.event_res != EV_TX) |-> (out_ch.tx_len == LEN_SHORT))
    else $error("non-transmit result with frame length");

endmodule

// File: rtl/mfk_dp.sv
// ----------------------------------------------------------------------------
// mfk_dp: link keepalive datapath
// Holds the registers, per-face state, the face counter of the send pass
// and the result register; acts on commands from the controller.
// ----------------------------------------------------------------------------
module mfk_dp #(
  parameter int FACES = mfk_pkg::FACES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mfk_pkg::item_t item_in,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_idx,
  input  logic [15:0]    cfg_data,
  input  mfk_pkg::cmd_t  cmd,
  output mfk_pkg::sts_t  sts,
  input  logic           out_ready,
  output logic           out_valid,
  output mfk_pkg::res_t  res
);
  import mfk_pkg::*;

  localparam int FW = (FACES > 1) ? $clog2(FACES) : 1;

  // Latched request
  item_t item_r;

  // Registers
  logic [15:0] rx_expire_r, tx_probe_r, lockout_r;
  logic [7:0]  user_type_r, sleep_val_r;

  // Per-face state
  logic [7:0]       rv_r   [FACES];
  logic [31:0]      exp_r  [FACES];
  logic [7:0]       og_r   [FACES];
  logic [31:0]      dl_r   [FACES];
  logic [7:0]       pq_r   [FACES];
  logic [FACES-1:0] pp_r;
  logic [31:0]      lock_end_r;

  // Request progress
  logic [2:0]    ev_pend_r;
  logic          chg_r;
  logic [FW-1:0] cnt_r;

  // Result register
  logic out_valid_r, out_valid_nxt;
  res_t res_r, res_nxt;

  logic          face_ok;
  logic [FW-1:0] fi;
  logic          type_hit, hdr_ok, rx_hit, pp_hdr, lock_out;
  logic          ev3, ev1, ev2;
  logic          q_chg;
  logic [FACES-1:0] busy_ext, exp_f;
  logic          slot_free;

  // Decode the latched request
  assign face_ok  = ({1'b0, item_r.face} < 4'(FACES));
  assign fi       = item_r.face[FW-1:0];
  assign type_hit = (item_r.packet_type == user_type_r);
  assign hdr_ok   = ((item_r.packet_len - 8'd1) > 8'd1);
  assign rx_hit   = face_ok && type_hit && hdr_ok;
  assign pp_hdr   = item_r.header_byte[7] && item_r.header_byte[6];
  assign lock_out = (item_r.now_ms >= lock_end_r);
  assign ev3      = rx_hit && pp_hdr && lock_out;
  assign ev1      = rx_hit && pp_hdr;
  assign ev2      = rx_hit && !item_r.header_byte[7] &&
                    (item_r.value_byte == sleep_val_r) &&
                    (item_r.header_byte == sleep_val_r);
  assign q_chg    = face_ok && (rv_r[fi] != pq_r[fi]);

  // Busy bits and expiry flags per face
  for (genvar g = 0; g < FACES; g++) begin : g_face
    if (g < BUSY_W) begin : g_busy
      assign busy_ext[g] = item_r.busy_mask[g];
    end else begin : g_free
      assign busy_ext[g] = 1'b0;
    end
    assign exp_f[g] = (exp_r[g] < item_r.now_ms);
  end

  assign slot_free = !out_valid_r || out_ready;

  // Status to the controller
  always_comb begin
    sts.mode      = item_r.mode;
    sts.ev_any    = |ev_pend_r;
    sts.slot_free = slot_free;
    sts.due       = (dl_r[cnt_r] <= item_r.now_ms);
    sts.busy      = busy_ext[cnt_r];
    sts.cnt_last  = (cnt_r == FW'(FACES - 1));
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item_in;
    end
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_expire_r <= RX_EXPIRE_RST;
      tx_probe_r  <= TX_PROBE_RST;
      lockout_r   <= LOCKOUT_RST;
      user_type_r <= USER_TYPE_RST;
      sleep_val_r <= SLEEP_VAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RX_EXPIRE: rx_expire_r <= cfg_data;
        REG_TX_PROBE:  tx_probe_r  <= cfg_data;
        REG_LOCKOUT:   lockout_r   <= cfg_data;
        REG_USER_TYPE: user_type_r <= cfg_data[7:0];
        REG_SLEEP_VAL: sleep_val_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Per-face state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int f = 0; f < FACES; f++) begin
        rv_r[f]  <= '0;
        exp_r[f] <= '0;
        og_r[f]  <= '0;
        dl_r[f]  <= '0;
        pq_r[f]  <= '0;
      end
      pp_r       <= '0;
      lock_end_r <= '0;
    end else begin
      if (cmd.exec) begin
        case (item_r.mode)
          MODE_RX: begin
            if (face_ok) begin
              exp_r[fi] <= item_r.now_ms + {16'b0, rx_expire_r};
              if (type_hit) begin
                dl_r[fi] <= '0;
                rv_r[fi] <= item_r.value_byte;
              end
              // Arm the lockout and flag every face
              if (ev3) begin
                lock_end_r <= item_r.now_ms + {16'b0, lockout_r};
                pp_r       <= '1;
              end
            end
          end
          MODE_SET: begin
            if (item_r.all_faces) begin
              for (int f = 0; f < FACES; f++) og_r[f] <= item_r.value_byte;
            end else if (face_ok) begin
              og_r[fi] <= item_r.value_byte;
            end
          end
          MODE_QUERY: begin
            if (q_chg) begin
              pq_r[fi] <= rv_r[fi];
            end
          end
          default: ;
        endcase
      end
      // Re-arm the probe time of a due face
      if (cmd.send_upd) begin
        dl_r[cnt_r] <= item_r.real_ms + {16'b0, tx_probe_r};
      end
      if (cmd.emit_tx) begin
        pp_r[cnt_r] <= 1'b0;
      end
    end
  end

  // Pending events, changed flag and face counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_pend_r <= '0;
      chg_r     <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (cmd.exec) begin
        ev_pend_r <= (item_r.mode == MODE_RX) ? {ev2, ev1, ev3} : 3'b000;
        chg_r     <= (item_r.mode == MODE_QUERY) && q_chg;
      end else if (cmd.emit_evt) begin
        // drop the lowest pending event
        ev_pend_r <= ev_pend_r & (ev_pend_r - 3'd1);
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + FW'(1);
      end
    end
  end

  // Build the next result
  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.emit_evt || cmd.emit_tx || cmd.emit_stat) begin
      out_valid_nxt      = 1'b1;
      res_nxt.event_res  = EV_STATUS;
      res_nxt.event_face = item_r.face;
      res_nxt.tx_value   = '0;
      res_nxt.tx_header  = '0;
      res_nxt.tx_len     = LEN_SHORT;
      res_nxt.last_value = '0;
      res_nxt.expired    = 1'b0;
      res_nxt.alone      = 1'b0;
      res_nxt.changed    = 1'b0;
      res_nxt.last       = 1'b0;
      if (cmd.emit_evt) begin
        if (ev_pend_r[0]) begin
          res_nxt.event_res = EV_RESET_TIMER;
        end else if (ev_pend_r[1]) begin
          res_nxt.event_res = EV_POSTPONE;
        end else begin
          res_nxt.event_res = EV_WARM_SLEEP;
        end
      end else if (cmd.emit_tx) begin
        res_nxt.event_res  = EV_TX;
        res_nxt.event_face = 3'(cnt_r);
        res_nxt.tx_value   = og_r[cnt_r];
        res_nxt.tx_header  = pp_r[cnt_r] ? HDR_POSTPONE : HDR_NORMAL;
        res_nxt.tx_len     = pp_r[cnt_r] ? LEN_LONG : LEN_SHORT;
      end else begin
        res_nxt.last_value = face_ok ? rv_r[fi] : 8'd0;
        res_nxt.expired    = face_ok ? exp_f[fi] : 1'b1;
        res_nxt.alone      = &exp_f;
        res_nxt.changed    = chg_r;
        res_nxt.last       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

// File: rtl/mfk_ctrl.sv
// ----------------------------------------------------------------------------
// mfk_ctrl: link keepalive controller
// Sequences one request: accept, apply, emit events or walk the send pass,
// then emit the closing status.
// ----------------------------------------------------------------------------
module mfk_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mfk_pkg::sts_t sts,
  output mfk_pkg::cmd_t cmd
);
  import mfk_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec    = 1'b1;
        cmd.cnt_clr = 1'b1;
        unique case (sts.mode) inside
          MODE_RX:              state_nxt = ST_EVT;
          MODE_SEND:            state_nxt = ST_SEND;
          MODE_SET, MODE_QUERY: state_nxt = ST_STAT;
          default:              state_nxt = ST_STAT;
        endcase
      end
      ST_EVT: begin
        // drain pending events one per slot
        if (!sts.ev_any) begin
          state_nxt = ST_STAT;
        end else if (sts.slot_free) begin
          cmd.emit_evt = 1'b1;
        end
      end
      ST_SEND: begin
        // a due, idle face waits for a free slot; others advance at once
        if (sts.due && !sts.busy) begin
          if (sts.slot_free) begin
            cmd.emit_tx  = 1'b1;
            cmd.send_upd = 1'b1;
            if (sts.cnt_last) state_nxt = ST_STAT;
            else              cmd.cnt_inc = 1'b1;
          end
        end else begin
          cmd.send_upd = sts.due;
          if (sts.cnt_last) state_nxt = ST_STAT;
          else              cmd.cnt_inc = 1'b1;
        end
      end
      ST_STAT: begin
        if (sts.slot_free) begin
          cmd.emit_stat = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: bench/multi_face_link_keepalive_test.sv
// ----------------------------------------------------------------------------
// multi_face_link_keepalive_test: self-checking bench of the link keepalive
// Drives receive, send-pass, set and query requests under several register
// settings, predicts every transmit, event and status result per face and
// compares each result in arrival order, with random gaps on both channels.
// ----------------------------------------------------------------------------
module multi_face_link_keepalive_test;
  import mfk_pkg::*;

  localparam int FACES           = FACES_DEF;
  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 11;
  localparam int SETTLE_CYCLES   = 16;
  localparam int LIMIT_CYCLES    = 2000;
  localparam int ITEMS_PER_PHASE = 38;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // Link state mirror: predicts the results of each accepted request
  class link_scoreboard;
    logic [15:0] rx_expire_ms;
    logic [15:0] tx_probe_ms;
    logic [15:0] lockout_ms;
    logic [7:0]  user_type;
    logic [7:0]  sleep_value;
    logic [7:0]  rx_value [FACES];
    logic [31:0] expiry_at [FACES];
    logic [7:0]  send_value [FACES];
    logic        postpone [FACES];
    logic [31:0] probe_due [FACES];
    logic [7:0]  queried_value [FACES];
    logic [31:0] lockout_until;
    res_t        expected_events [$];
    int          errors;

    function new();
      rx_expire_ms  = RX_EXPIRE_RST;
      tx_probe_ms   = TX_PROBE_RST;
      lockout_ms    = LOCKOUT_RST;
      user_type     = USER_TYPE_RST;
      sleep_value   = SLEEP_VAL_RST;
      lockout_until = '0;
      errors        = 0;
      for (int f = 0; f < FACES; f++) begin
        rx_value[f]      = '0;
        expiry_at[f]     = '0;
        send_value[f]    = '0;
        postpone[f]      = 1'b0;
        probe_due[f]     = '0;
        queried_value[f] = '0;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_RX_EXPIRE: rx_expire_ms = data;
        REG_TX_PROBE:  tx_probe_ms  = data;
        REG_LOCKOUT:   lockout_ms   = data;
        REG_USER_TYPE: user_type    = data[7:0];
        REG_SLEEP_VAL: sleep_value  = data[7:0];
        default: ;
      endcase
    endfunction

    function res_t link_event(ev_t ev, logic [2:0] face);
      res_t e;
      e            = '0;
      e.event_res  = ev;
      e.event_face = face;
      e.tx_len     = LEN_SHORT;
      return e;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    // Apply one request to the mirror and queue the results it causes
    function void note_request(item_t r);
      logic       in_range;
      logic       chg;
      logic       lone;
      logic [7:0] len_m1;
      res_t       e;
      int         k;
      in_range = (r.face < FACES);
      k        = int'(r.face);
      chg      = 1'b0;
      len_m1   = r.packet_len - 8'd1;
      case (r.mode)
        MODE_RX: begin
          if (in_range) begin
            expiry_at[k] = r.now_ms + {16'd0, rx_expire_ms};
            if (r.packet_type == user_type) begin
              probe_due[k] = '0;
              rx_value[k]  = r.value_byte;
              if (len_m1 > 8'd1) begin
                if (r.header_byte[7]) begin
                  if (r.header_byte[6]) begin
                    // viral postpone: only when the lockout has run out
                    if (r.now_ms >= lockout_until) begin
                      lockout_until = r.now_ms + {16'd0, lockout_ms};
                      for (int f = 0; f < FACES; f++) postpone[f] = 1'b1;
                      expected_events.push_back(link_event(EV_RESET_TIMER, r.face));
                    end
                    expected_events.push_back(link_event(EV_POSTPONE, r.face));
                  end
                end else if (r.value_byte == sleep_value &&
                             r.header_byte == sleep_value) begin
                  expected_events.push_back(link_event(EV_WARM_SLEEP, r.face));
                end
              end
            end
          end
        end
        MODE_SEND: begin
          for (int f = 0; f < FACES; f++) begin
            if (probe_due[f] <= r.now_ms) begin
              if (!(f < BUSY_W && r.busy_mask[f])) begin
                e           = link_event(EV_TX, 3'(f));
                e.tx_value  = send_value[f];
                e.tx_header = postpone[f] ? HDR_POSTPONE : HDR_NORMAL;
                e.tx_len    = postpone[f] ? LEN_LONG : LEN_SHORT;
                expected_events.push_back(e);
                postpone[f] = 1'b0;
              end
              probe_due[f] = r.real_ms + {16'd0, tx_probe_ms};
            end
          end
        end
        MODE_SET: begin
          if (r.all_faces) begin
            for (int f = 0; f < FACES; f++) send_value[f] = r.value_byte;
          end else if (in_range) begin
            send_value[k] = r.value_byte;
          end
        end
        default: begin
          if (in_range && rx_value[k] != queried_value[k]) begin
            queried_value[k] = rx_value[k];
            chg = 1'b1;
          end
        end
      endcase
      // closing status of the request
      lone = 1'b1;
      for (int f = 0; f < FACES; f++) if (!(expiry_at[f] < r.now_ms)) lone = 1'b0;
      e         = link_event(EV_STATUS, r.face);
      e.expired = 1'b1;
      if (in_range) begin
        e.last_value = rx_value[k];
        e.expired    = expiry_at[k] < r.now_ms;
      end
      e.alone   = lone;
      e.changed = chg;
      e.last    = 1'b1;
      expected_events.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_events.size() == 0) begin
        errors++;
        $error("unexpected result: event %0d face %0d", got.event_res, got.event_face);
        return;
      end
      want = expected_events.pop_front();
      compare_field("event_res", 32'(want.event_res), 32'(got.event_res));
      compare_field("event_face", 32'(want.event_face), 32'(got.event_face));
      compare_field("tx_value", 32'(want.tx_value), 32'(got.tx_value));
      compare_field("tx_header", 32'(want.tx_header), 32'(got.tx_header));
      compare_field("tx_len", 32'(want.tx_len), 32'(got.tx_len));
      compare_field("last_value", 32'(want.last_value), 32'(got.last_value));
      compare_field("expired", 32'(want.expired), 32'(got.expired));
      compare_field("alone", 32'(want.alone), 32'(got.alone));
      compare_field("changed", 32'(want.changed), 32'(got.changed));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  mfk_in_if  in_bus ();
  mfk_out_if out_bus ();
  mfk_cfg_if cfg_bus ();

  link_scoreboard sb;
  logic [31:0]    clock_ms;
  logic           steady_source;
  logic           steady_sink;
  int             quiet_cycles;

  multi_face_link_keepalive i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Sample accepted transfers on all three channels
  always @(posedge clk) begin
    item_t r;
    res_t  got;
    if (rst_n) begin
      quiet_cycles = quiet_cycles + 1;
      if (out_bus.valid && out_bus.ready) begin
        got.event_res  = ev_t'(out_bus.event_res);
        got.event_face = out_bus.event_face;
        got.tx_value   = out_bus.tx_value;
        got.tx_header  = out_bus.tx_header;
        got.tx_len     = out_bus.tx_len;
        got.last_value = out_bus.last_value;
        got.expired    = out_bus.expired;
        got.alone      = out_bus.alone;
        got.changed    = out_bus.changed;
        got.last       = out_bus.last;
        sb.check_result(got);
        quiet_cycles = 0;
      end
      if (in_bus.valid && in_bus.ready) begin
        r.mode        = mode_t'(in_bus.mode);
        r.face        = in_bus.face;
        r.now_ms      = in_bus.now_ms;
        r.real_ms     = in_bus.real_ms;
        r.packet_type = in_bus.packet_type;
        r.packet_len  = in_bus.packet_len;
        r.value_byte  = in_bus.value_byte;
        r.header_byte = in_bus.header_byte;
        r.busy_mask   = in_bus.busy_mask;
        r.all_faces   = in_bus.all_faces;
        sb.note_request(r);
        quiet_cycles = 0;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        sb.write_reg(cfg_bus.index, cfg_bus.data);
        quiet_cycles = 0;
      end
    end
  end

  // Abort when nothing moves for too long
  initial begin : watchdog
    wait (rst_n === 1'b1);
    while (quiet_cycles < LIMIT_CYCLES) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Result sink: mostly ready, short stalls, now and then a long one
  initial begin : result_sink
    int   hold;
    logic stall_now;
    hold          = 0;
    stall_now     = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        if (steady_sink || $urandom_range(0, 3) != 0) begin
          stall_now = 1'b0;
          hold      = $urandom_range(1, 12);
        end else begin
          stall_now = 1'b1;
          hold = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
      end
      out_bus.ready = !stall_now;
      hold--;
    end
  end

  function automatic int pick_gap();
    int p;
    if (steady_source) return 0;
    p = $urandom_range(0, 19);
    if (p < 11) return 0;
    if (p < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t make_request(mode_t m, logic [2:0] face, logic [31:0] now,
                                         logic [31:0] real_t, logic [7:0] ptype,
                                         logic [7:0] plen, logic [7:0] value,
                                         logic [7:0] hdr, logic [5:0] busy,
                                         logic all_f);
    item_t r;
    r.mode        = m;
    r.face        = face;
    r.now_ms      = now;
    r.real_ms     = real_t;
    r.packet_type = ptype;
    r.packet_len  = plen;
    r.value_byte  = value;
    r.header_byte = hdr;
    r.busy_mask   = busy;
    r.all_faces   = all_f;
    return r;
  endfunction

  // Mostly well-formed link traffic on an advancing clock, some noise
  function automatic item_t random_request();
    item_t r;
    int    p;
    p = $urandom_range(0, 19);
    if (p < 14) clock_ms += $urandom_range(0, 40);
    else if (p < 19) clock_ms += $urandom_range(100, 2500);
    else clock_ms += $urandom();
    r.now_ms  = ($urandom_range(0, 24) == 0) ? $urandom() : clock_ms;
    r.real_ms = ($urandom_range(0, 9) == 0) ? $urandom() : clock_ms + $urandom_range(0, 20);
    r.face    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
    r.packet_type = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : sb.user_type;
    r.packet_len  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(3, 255))
                                               : 8'($urandom_range(0, 2));
    r.value_byte  = 8'($urandom_range(0, 255));
    p = $urandom_range(0, 9);
    if (p < 4) r.header_byte = 8'hC0 | 8'($urandom_range(0, 63));
    else if (p < 6) r.header_byte = 8'h80 | 8'($urandom_range(0, 63));
    else if (p < 7) r.header_byte = 8'($urandom_range(0, 127));
    else if (p < 9) begin
      r.header_byte = sb.sleep_value;
      r.value_byte  = sb.sleep_value;
    end else r.header_byte = 8'($urandom_range(0, 255));
    r.busy_mask = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(0, 63));
    r.all_faces = ($urandom_range(0, 3) == 0);
    p = $urandom_range(0, 19);
    if (p < 8) r.mode = MODE_RX;
    else if (p < 13) r.mode = MODE_SEND;
    else if (p < 16) r.mode = MODE_SET;
    else r.mode = MODE_QUERY;
    return r;
  endfunction

  // Present one request after a random gap; return once it is taken
  task automatic send_request(input item_t r);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.mode        = r.mode;
    in_bus.face        = r.face;
    in_bus.now_ms      = r.now_ms;
    in_bus.real_ms     = r.real_ms;
    in_bus.packet_type = r.packet_type;
    in_bus.packet_len  = r.packet_len;
    in_bus.value_byte  = r.value_byte;
    in_bus.header_byte = r.header_byte;
    in_bus.busy_mask   = r.busy_mask;
    in_bus.all_faces   = r.all_faces;
    in_bus.valid       = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Hold off new requests until every result is in and the block is idle
  task automatic wait_for_results();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    cfg_bus.valid = 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Byte registers get random upper bits half of the time
  task automatic load_settings(input logic [15:0] rx_exp, input logic [15:0] probe,
                               input logic [15:0] lock, input logic [7:0] utype,
                               input logic [7:0] sleep_v);
    write_register(REG_RX_EXPIRE, rx_exp);
    write_register(REG_TX_PROBE, probe);
    write_register(REG_LOCKOUT, lock);
    write_register(REG_USER_TYPE, {8'($urandom_range(0, 1) * $urandom_range(0, 255)), utype});
    write_register(REG_SLEEP_VAL, {8'($urandom_range(0, 1) * $urandom_range(0, 255)), sleep_v});
  endtask

  initial begin
    int phase;
    int n;
    int pause_at;
    sb            = new();
    rst_n         = 1'b0;
    clock_ms      = '0;
    steady_source = 1'b0;
    steady_sink   = 1'b0;
    quiet_cycles  = 0;
    in_bus.valid       = 1'b0;
    in_bus.mode        = '0;
    in_bus.face        = '0;
    in_bus.now_ms      = '0;
    in_bus.real_ms     = '0;
    in_bus.packet_type = '0;
    in_bus.packet_len  = '0;
    in_bus.value_byte  = '0;
    in_bus.header_byte = '0;
    in_bus.busy_mask   = '0;
    in_bus.all_faces   = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = '0;
    cfg_bus.data       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings, every mode, header cases and time extremes
    send_request(make_request(MODE_QUERY, 3'd0, 32'd0, 32'd0, 8'h00, 8'd3, 8'h00, 8'h00,
                              6'd0, 1'b0));
    send_request(make_request(MODE_RX, 3'd0, 32'd10, 32'd10, 8'h00, 8'd3, 8'h5A, 8'hC0,
                              6'd0, 1'b0));
    send_request(make_request(MODE_RX, 3'd1, 32'd20, 32'd20, 8'h00, 8'd3, 8'h11, 8'hC5,
                              6'd0, 1'b0));
    send_request(make_request(MODE_RX, 3'd2, 32'd30, 32'd30, 8'h00, 8'd2, 8'h00, 8'h00,
                              6'd0, 1'b0));
    send_request(make_request(MODE_RX, 3'd2, 32'd31, 32'd31, 8'h00, 8'd3, 8'h00, 8'h00,
                              6'd0, 1'b0));
    send_request(make_request(MODE_RX, 3'd3, 32'd32, 32'd32, 8'h55, 8'd3, 8'h77, 8'hC0,
                              6'd0, 1'b0));
    send_request(make_request(MODE_RX, 3'd4, 32'd33, 32'd33, 8'h00, 8'd0, 8'h00, 8'h00,
                              6'd0, 1'b0));
    send_request(make_request(MODE_RX, 3'd4, 32'd34, 32'd34, 8'h00, 8'd1, 8'h00, 8'h00,
                              6'd0, 1'b0));
    send_request(make_request(MODE_RX, 3'd5, 32'd35, 32'd35, 8'h00, 8'd255, 8'hFF, 8'hFF,
                              6'd0, 1'b0));
    send_request(make_request(MODE_SET, 3'd6, 32'd36, 32'd36, 8'h00, 8'd3, 8'h3C, 8'h00,
                              6'd0, 1'b1));
    send_request(make_request(MODE_SET, 3'd5, 32'd37, 32'd37, 8'h00, 8'd3, 8'hA5, 8'h00,
                              6'd0, 1'b0));
    send_request(make_request(MODE_SET, 3'd7, 32'd38, 32'd38, 8'h00, 8'd3, 8'h33, 8'h00,
                              6'd0, 1'b0));
    send_request(make_request(MODE_SEND, 3'd0, 32'd40, 32'd40, 8'h00, 8'd3, 8'h00, 8'h00,
                              6'b000010, 1'b0));
    send_request(make_request(MODE_SEND, 3'd1, 32'd45, 32'd45, 8'h00, 8'd3, 8'h00, 8'h00,
                              6'd0, 1'b0));
    send_request(make_request(MODE_SEND, 3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 8'd3,
                              8'h00, 8'h00, 6'b111111, 1'b0));
    send_request(make_request(MODE_SEND, 3'd3, 32'hFFFF_FFFF, 32'd0, 8'h00, 8'd3, 8'h00,
                              8'h00, 6'd0, 1'b0));
    send_request(make_request(MODE_QUERY, 3'd0, 32'd50, 32'd50, 8'h00, 8'd3, 8'h00, 8'h00,
                              6'd0, 1'b0));
    send_request(make_request(MODE_QUERY, 3'd0, 32'd50, 32'd50, 8'h00, 8'd3, 8'h00, 8'h00,
                              6'd0, 1'b0));
    send_request(make_request(MODE_QUERY, 3'd7, 32'd50, 32'd50, 8'h00, 8'd3, 8'h00, 8'h00,
                              6'd0, 1'b0));
    send_request(make_request(MODE_RX, 3'd6, 32'd60, 32'd60, 8'h00, 8'd3, 8'h42, 8'hC0,
                              6'd0, 1'b0));
    send_request(make_request(MODE_QUERY, 3'd3, 32'hFFFF_FFFF, 32'd0, 8'h00, 8'd3, 8'h00,
                              8'h00, 6'd0, 1'b0));
    send_request(make_request(MODE_RX, 3'd0, 32'd2100, 32'd2100, 8'h00, 8'd3, 8'h81, 8'hC0,
                              6'd0, 1'b0));
    clock_ms = 32'd2100;

    // Random phases, each under its own register setting
    for (phase = 1; phase <= 6; phase++) begin
      wait_for_results();
      steady_source = 1'b0;
      steady_sink   = 1'b0;
      case (phase)
        1: load_settings(16'd1, 16'd1, 16'd1, 8'h00, 8'h00);
        2: begin
          load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
          steady_source = 1'b1;
          steady_sink   = 1'b1;
          clock_ms      = $urandom();
        end
        3: begin
          load_settings(16'd0, 16'd0, 16'd0, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 127)));
          write_register(REG_UNUSED, 16'($urandom()));
        end
        4: load_settings(16'($urandom_range(1, 400)), 16'($urandom_range(1, 300)),
                         16'($urandom_range(1, 3000)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 127)));
        5: begin
          load_settings(16'($urandom()), 16'($urandom()), 16'($urandom()),
                        8'($urandom()), 8'($urandom()));
          steady_source = 1'b1;
        end
        default: begin
          load_settings(RX_EXPIRE_RST, TX_PROBE_RST, LOCKOUT_RST, USER_TYPE_RST,
                        SLEEP_VAL_RST);
          clock_ms = 32'hFFFF_F000;
        end
      endcase
      pause_at = $urandom_range(5, 30);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == pause_at) wait_for_results();
        send_request(random_request());
      end
    end

    wait_for_results();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/mfk_pkg.sv
rtl/mfk_in_if.sv
rtl/mfk_out_if.sv
rtl/mfk_cfg_if.sv
rtl/mfk_dp.sv
rtl/mfk_ctrl.sv
rtl/multi_face_link_keepalive.sv
bench/multi_face_link_keepalive_test.sv
